>>> sv/prg_pkg.sv
`default_nettype none
package prg_pkg;

  // packed field widths of the camera registers
  localparam int ORIGIN_W  = 20;
  localparam int FWD_W     = 18;
  localparam int STEP_W    = 20;
  localparam int DIR_W     = 16;
  localparam int PIX_W     = 16;
  localparam int CFG_W     = 60;
  localparam int CFG_IDX_W = 3;
  localparam int RES_FIELD_W = 13;

  // normalization datapath
  localparam int MAG_W  = 30;
  localparam int SQ_W   = 2 * MAG_W;
  localparam int RAD_W  = SQ_W + 2;
  localparam int ROOT_W = RAD_W / 2;
  localparam int Q_W    = 15;
  localparam int FRAC_W = 14;
  localparam int DIR_ONE = 16384;

  localparam int DEFAULT_MAX_RESOLUTION = 4096;

  // register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ORIGIN  = 3'd0,
    REG_FORWARD = 3'd1,
    REG_HSTEP   = 3'd2,
    REG_VSTEP   = 3'd3,
    REG_WIDTH   = 3'd4,
    REG_HEIGHT  = 3'd5
  } prg_reg_t;

  localparam logic [59:0] ORIGIN_RST  = 60'd0;
  localparam logic [53:0] FORWARD_RST = 54'd17179869184;
  localparam logic [59:0] HSTEP_RST   = 60'd403646111719358464;
  localparam logic [59:0] VSTEP_RST   = 60'd681462;

  // per-ray data carried alongside the square root
  typedef struct packed {
    logic [2:0][MAG_W-1:0] mag;
    logic [2:0]            neg;
  } prg_side_t;

endpackage
`default_nettype wire

>>> sv/prg_isqrt.sv
`default_nettype none
module prg_isqrt import prg_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  input  wire logic [RAD_W-1:0]  in_rad,
  input  wire prg_side_t         in_side,
  output logic                   out_valid,
  output logic [ROOT_W-1:0]      out_root,
  output prg_side_t              out_side
);

  localparam int REM_W = ROOT_W + 3;

  logic              vld  [ROOT_W+1];
  logic [RAD_W-1:0]  rad  [ROOT_W+1];
  logic [REM_W-1:0]  rem  [ROOT_W+1];
  logic [ROOT_W-1:0] root [ROOT_W+1];
  prg_side_t         side [ROOT_W+1];

  assign vld[0]  = in_valid;
  assign rad[0]  = in_rad;
  assign rem[0]  = '0;
  assign root[0] = '0;
  assign side[0] = in_side;

  // one root bit per stage, restoring digit recurrence
  for (genvar s = 0; s < ROOT_W; s++) begin : g_stage
    logic [REM_W-1:0] rem_sh;
    logic [REM_W-1:0] trial;
    logic             take;

    always_comb begin
      rem_sh = {rem[s][REM_W-3:0], rad[s][RAD_W-1 -: 2]};
      trial  = REM_W'({root[s], 2'b01});
      take   = rem_sh >= trial;
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s+1] <= 1'b0;
      end else begin
        vld[s+1] <= vld[s];
      end
      rad[s+1]  <= {rad[s][RAD_W-3:0], 2'b00};
      rem[s+1]  <= take ? rem_sh - trial : rem_sh;
      root[s+1] <= {root[s][ROOT_W-2:0], take};
      side[s+1] <= side[s];
    end
  end

  assign out_valid = vld[ROOT_W];
  assign out_root  = root[ROOT_W];
  assign out_side  = side[ROOT_W];

endmodule
`default_nettype wire

>>> sv/prg_div.sv
`default_nettype none
module prg_div import prg_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  input  wire logic [ROOT_W-1:0]     in_n,
  input  wire prg_side_t             in_side,
  output logic                       out_valid,
  output logic [2:0][Q_W-1:0]        out_q,
  output logic [2:0]                 out_neg,
  output logic                       out_zero
);

  localparam int DREM_W = ROOT_W + Q_W;

  logic                   vld  [Q_W+1];
  logic [ROOT_W-1:0]      den  [Q_W+1];
  logic [2:0][DREM_W-1:0] rem  [Q_W+1];
  logic [2:0][Q_W-1:0]    quo  [Q_W+1];
  logic [2:0]             neg  [Q_W+1];

  // rounded numerator: mag * 2^14 + n/2
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      rem[0][i] = DREM_W'({in_side.mag[i], {FRAC_W{1'b0}}}) + DREM_W'(in_n >> 1);
      quo[0][i] = '0;
    end
  end
  assign vld[0] = in_valid;
  assign den[0] = in_n;
  assign neg[0] = in_side.neg;

  // one quotient bit per stage, three lanes
  for (genvar j = 0; j < Q_W; j++) begin : g_stage
    localparam int SH = Q_W - 1 - j;
    logic [DREM_W-1:0] dsh;
    logic [2:0]        take;

    always_comb begin
      dsh = DREM_W'(den[j]) << SH;
      for (int i = 0; i < 3; i++) begin
        take[i] = rem[j][i] >= dsh;
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[j+1] <= 1'b0;
      end else begin
        vld[j+1] <= vld[j];
      end
      den[j+1] <= den[j];
      neg[j+1] <= neg[j];
      for (int i = 0; i < 3; i++) begin
        rem[j+1][i] <= take[i] ? rem[j][i] - dsh : rem[j][i];
        quo[j+1][i] <= {quo[j][i][Q_W-2:0], take[i]};
      end
    end
  end

  assign out_valid = vld[Q_W];
  assign out_q     = quo[Q_W];
  assign out_neg   = neg[Q_W];
  assign out_zero  = den[Q_W] == '0;

endmodule
`default_nettype wire

>>> sv/primary_ray_generator_core.sv
`default_nettype none
// Pinhole camera primary ray generator. One pixel (12.4 fixed point) is taken
// in every cycle; busy is never raised. The ray (camera origin and Q1.14 unit
// direction) appears with done for one cycle once start has passed through the
// stages of offset, multiply, sum, range shift, square and accumulate, the
// bit-per-stage square root, the bit-per-stage divider and one output
// register. The receiver cannot stall the block; every ray must be taken in
// the cycle done is high. Camera registers are written through
// cfg_we/cfg_index/cfg_data and must only change while no ray is in flight.
module primary_ray_generator_core import prg_pkg::*; #(
  parameter int MAX_RESOLUTION = DEFAULT_MAX_RESOLUTION
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  start,
  output logic                       busy,
  input  wire logic [PIX_W-1:0]      pixel_x,
  input  wire logic [PIX_W-1:0]      pixel_y,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_W-1:0]      cfg_data,
  output logic                       done,
  output logic signed [ORIGIN_W-1:0] origin_x,
  output logic signed [ORIGIN_W-1:0] origin_y,
  output logic signed [ORIGIN_W-1:0] origin_z,
  output logic signed [DIR_W-1:0]    dir_x,
  output logic signed [DIR_W-1:0]    dir_y,
  output logic signed [DIR_W-1:0]    dir_z
);

  localparam int RES_W  = $clog2(MAX_RESOLUTION + 1);
  localparam int OFF_W  = (RES_W + 4 > 18) ? RES_W + 4 : 18;
  localparam int PROD_W = STEP_W + OFF_W;
  localparam int SUM_W  = PROD_W + 2;
  localparam int K_W    = $clog2(SUM_W);

  // camera registers
  logic [59:0]      camera_origin;
  logic [53:0]      forward_vector;
  logic [59:0]      horizontal_step;
  logic [59:0]      vertical_step;
  logic [RES_W-1:0] image_width;
  logic [RES_W-1:0] image_height;

  function automatic logic [RES_W-1:0] clamp_res(input logic [RES_FIELD_W-1:0] raw);
    logic [RES_W-1:0] r;
    if (raw == '0) begin
      r = RES_W'(1);
    end else if (32'(raw) > MAX_RESOLUTION) begin
      r = RES_W'(MAX_RESOLUTION);
    end else begin
      r = RES_W'(raw);
    end
    return r;
  endfunction

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      camera_origin   <= ORIGIN_RST;
      forward_vector  <= FORWARD_RST;
      horizontal_step <= HSTEP_RST;
      vertical_step   <= VSTEP_RST;
      image_width     <= RES_W'(1);
      image_height    <= RES_W'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ORIGIN:  camera_origin   <= cfg_data;
        REG_FORWARD: forward_vector  <= cfg_data[53:0];
        REG_HSTEP:   horizontal_step <= cfg_data;
        REG_VSTEP:   vertical_step   <= cfg_data;
        REG_WIDTH:   image_width     <= clamp_res(cfg_data[RES_FIELD_W-1:0]);
        REG_HEIGHT:  image_height    <= clamp_res(cfg_data[RES_FIELD_W-1:0]);
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;

  // stage 1: offsets from image center in 1/16 pixel
  logic                    v1;
  logic signed [OFF_W-1:0] offx, offy;
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= start;
    end
    offx <= $signed({{(OFF_W-PIX_W){1'b0}}, pixel_x})
          - $signed({{(OFF_W-RES_W-3){1'b0}}, image_width, 3'b000});
    offy <= $signed({{(OFF_W-PIX_W){1'b0}}, pixel_y})
          - $signed({{(OFF_W-RES_W-3){1'b0}}, image_height, 3'b000});
  end

  // stage 2: step products
  logic                     v2;
  logic signed [PROD_W-1:0] ph [3];
  logic signed [PROD_W-1:0] pv [3];
  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else begin
      v2 <= v1;
    end
    for (int i = 0; i < 3; i++) begin
      ph[i] <= $signed(horizontal_step[STEP_W*i +: STEP_W]) * offx;
      pv[i] <= $signed(vertical_step[STEP_W*i +: STEP_W]) * offy;
    end
  end

  // stage 3: direction sum, sign and magnitude
  logic                    v3;
  logic [2:0][SUM_W-1:0]   mag3;
  logic [2:0]              neg3;
  always_ff @(posedge clk) begin
    logic signed [SUM_W-1:0] s;
    logic signed [FWD_W-1:0] f;
    if (rst) begin
      v3 <= 1'b0;
    end else begin
      v3 <= v2;
    end
    for (int i = 0; i < 3; i++) begin
      f = $signed(forward_vector[FWD_W*i +: FWD_W]);
      s = $signed({{(SUM_W-FWD_W-6){f[FWD_W-1]}}, f, 6'b000000})
        + SUM_W'(ph[i]) + SUM_W'(pv[i]);
      neg3[i] <= s[SUM_W-1];
      mag3[i] <= s[SUM_W-1] ? SUM_W'(-s) : SUM_W'(s);
    end
  end

  // stage 4: shift needed to bring all magnitudes below 2^30
  logic                  v4;
  logic [2:0][SUM_W-1:0] mag4;
  logic [2:0]            neg4;
  logic [K_W-1:0]        k4;
  always_ff @(posedge clk) begin
    logic [SUM_W-1:0] all;
    logic [K_W-1:0]   kk;
    if (rst) begin
      v4 <= 1'b0;
    end else begin
      v4 <= v3;
    end
    all = mag3[0] | mag3[1] | mag3[2];
    kk  = '0;
    for (int b = MAG_W; b < SUM_W; b++) begin
      if (all[b]) begin
        kk = K_W'(b - MAG_W + 1);
      end
    end
    k4   <= kk;
    mag4 <= mag3;
    neg4 <= neg3;
  end

  // stage 5: range shift
  logic      v5;
  prg_side_t side5;
  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else begin
      v5 <= v4;
    end
    for (int i = 0; i < 3; i++) begin
      side5.mag[i] <= MAG_W'(mag4[i] >> k4);
    end
    side5.neg <= neg4;
  end

  // stage 6: squares
  logic           v6;
  prg_side_t      side6;
  logic [SQ_W-1:0] sq6 [3];
  always_ff @(posedge clk) begin
    if (rst) begin
      v6 <= 1'b0;
    end else begin
      v6 <= v5;
    end
    for (int i = 0; i < 3; i++) begin
      sq6[i] <= side5.mag[i] * side5.mag[i];
    end
    side6 <= side5;
  end

  // stage 7: squared length
  logic             v7;
  prg_side_t        side7;
  logic [RAD_W-1:0] sumsq;
  always_ff @(posedge clk) begin
    if (rst) begin
      v7 <= 1'b0;
    end else begin
      v7 <= v6;
    end
    sumsq <= RAD_W'(sq6[0]) + RAD_W'(sq6[1]) + RAD_W'(sq6[2]);
    side7 <= side6;
  end

  // length
  logic              sq_valid;
  logic [ROOT_W-1:0] sq_root;
  prg_side_t         sq_side;
  prg_isqrt u_isqrt (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v7),
    .in_rad    (sumsq),
    .in_side   (side7),
    .out_valid (sq_valid),
    .out_root  (sq_root),
    .out_side  (sq_side)
  );

  // rounded quotients
  logic                div_valid;
  logic [2:0][Q_W-1:0] div_q;
  logic [2:0]          div_neg;
  logic                div_zero;
  prg_div u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (sq_valid),
    .in_n      (sq_root),
    .in_side   (sq_side),
    .out_valid (div_valid),
    .out_q     (div_q),
    .out_neg   (div_neg),
    .out_zero  (div_zero)
  );

  // output register: clamp, sign, zero-length case
  logic [2:0][DIR_W-1:0] dir;
  always_ff @(posedge clk) begin
    logic [DIR_W-1:0] q;
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= div_valid;
    end
    for (int i = 0; i < 3; i++) begin
      q = DIR_W'(div_q[i]);
      if (q > DIR_W'(DIR_ONE)) begin
        q = DIR_W'(DIR_ONE);
      end
      if (div_zero) begin
        dir[i] <= '0;
      end else begin
        dir[i] <= div_neg[i] ? -q : q;
      end
    end
  end

  assign dir_x    = $signed(dir[0]);
  assign dir_y    = $signed(dir[1]);
  assign dir_z    = $signed(dir[2]);
  assign origin_x = $signed(camera_origin[ORIGIN_W*0 +: ORIGIN_W]);
  assign origin_y = $signed(camera_origin[ORIGIN_W*1 +: ORIGIN_W]);
  assign origin_z = $signed(camera_origin[ORIGIN_W*2 +: ORIGIN_W]);

`ifndef SYNTH
  a_done_follows_div: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(div_valid))
    else $error("done without divider transaction");
  a_no_done_after_reset: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !done)
    else $error("done right after reset");
  a_dir_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (dir_x >= -DIR_ONE && dir_x <= DIR_ONE && dir_y >= -DIR_ONE
              && dir_y <= DIR_ONE && dir_z >= -DIR_ONE && dir_z <= DIR_ONE))
    else $error("direction out of unit range");
`endif

endmodule
`default_nettype wire

>>> tb/sv/tb_primary_ray_generator_core.sv
`default_nettype none
module tb_primary_ray_generator_core;
  import prg_pkg::*;

  localparam int LATENCY = 54;
  localparam int DRAIN_CYCLES = LATENCY + 8;
  localparam int STALL_LIMIT = 5000;
  localparam int RANDOM_ITEMS = 1300;
  localparam int PHASES = 4;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 3'd7;

  typedef struct packed {
    logic signed [ORIGIN_W-1:0] ox;
    logic signed [ORIGIN_W-1:0] oy;
    logic signed [ORIGIN_W-1:0] oz;
    logic signed [DIR_W-1:0]    dx;
    logic signed [DIR_W-1:0]    dy;
    logic signed [DIR_W-1:0]    dz;
  } ray_t;

  typedef enum logic {ROW_PIX, ROW_CFG} row_kind_t;

  typedef struct packed {
    row_kind_t             kind;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_W-1:0]      data;
    logic [PIX_W-1:0]      px;
    logic [PIX_W-1:0]      py;
    logic                  typed;
    logic signed [DIR_W-1:0] ex;
    logic signed [DIR_W-1:0] ey;
    logic signed [DIR_W-1:0] ez;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic [PIX_W-1:0] pixel_x = '0;
  logic [PIX_W-1:0] pixel_y = '0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;
  logic busy, done;
  logic signed [ORIGIN_W-1:0] origin_x, origin_y, origin_z;
  logic signed [DIR_W-1:0] dir_x, dir_y, dir_z;

  // camera register mirror
  logic [59:0] cam_origin;
  logic [53:0] cam_forward;
  logic [59:0] cam_hstep;
  logic [59:0] cam_vstep;
  int unsigned cam_width;
  int unsigned cam_height;

  ray_t expected_rays[$];
  int errors = 0;
  int rays_checked = 0;
  int pixels_sent = 0;
  int cfg_writes = 0;
  int idle_pct = 0;
  int stall_count = 0;

  primary_ray_generator_core DUT (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .pixel_x(pixel_x), .pixel_y(pixel_y),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .done(done), .origin_x(origin_x), .origin_y(origin_y), .origin_z(origin_z),
    .dir_x(dir_x), .dir_y(dir_y), .dir_z(dir_z)
  );

  always #2 clk = ~clk;

  function automatic logic [63:0] int_sqrt(logic [63:0] x);
    logic [63:0] res;
    logic [63:0] b;
    res = 0;
    b = 64'd1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= res + b) begin
        x = x - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  // ray direction for one pixel under the mirrored camera
  function automatic ray_t trace_pixel(logic [PIX_W-1:0] px, logic [PIX_W-1:0] py);
    ray_t r;
    longint offx, offy, s;
    logic [63:0] mag[3];
    logic neg[3];
    logic [63:0] maxmag, sumsq, n, q;
    int k;
    offx = longint'(px) - longint'(cam_width * 8);
    offy = longint'(py) - longint'(cam_height * 8);
    maxmag = 0;
    sumsq = 0;
    k = 0;
    for (int i = 0; i < 3; i++) begin
      s = longint'($signed(cam_forward[18*i +: 18])) * 64
        + longint'($signed(cam_hstep[20*i +: 20])) * offx
        + longint'($signed(cam_vstep[20*i +: 20])) * offy;
      neg[i] = s < 0;
      mag[i] = neg[i] ? 64'(-s) : 64'(s);
      if (mag[i] > maxmag) maxmag = mag[i];
    end
    while ((maxmag >> k) >= (64'd1 << 30)) k++;
    for (int i = 0; i < 3; i++) begin
      mag[i] = mag[i] >> k;
      sumsq += mag[i] * mag[i];
    end
    n = int_sqrt(sumsq);
    r.ox = cam_origin[19:0];
    r.oy = cam_origin[39:20];
    r.oz = cam_origin[59:40];
    for (int i = 0; i < 3; i++) begin
      if (n == 0) begin
        q = 0;
      end else begin
        q = ((mag[i] << 14) + (n >> 1)) / n;
        if (q > DIR_ONE) q = DIR_ONE;
        if (neg[i]) q = -q;
      end
      case (i)
        0: r.dx = q[15:0];
        1: r.dy = q[15:0];
        default: r.dz = q[15:0];
      endcase
    end
    return r;
  endfunction

  function automatic int unsigned clamp_res(logic [CFG_W-1:0] d);
    int unsigned v;
    v = d[RES_FIELD_W-1:0];
    if (v == 0) return 1;
    if (v > DEFAULT_MAX_RESOLUTION) return DEFAULT_MAX_RESOLUTION;
    return v;
  endfunction

  // one register write; cfg_we is dropped again before the task returns
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] d);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    @(posedge clk);
    cfg_we <= 1'b0;
    cfg_writes++;
    case (idx)
      REG_ORIGIN:  cam_origin = d[59:0];
      REG_FORWARD: cam_forward = d[53:0];
      REG_HSTEP:   cam_hstep = d[59:0];
      REG_VSTEP:   cam_vstep = d[59:0];
      REG_WIDTH:   cam_width = clamp_res(d);
      REG_HEIGHT:  cam_height = clamp_res(d);
      default: ;
    endcase
    @(posedge clk);
  endtask

  // one pixel transaction; start stays high for a following item unless an idle gap is drawn
  task automatic send_pixel(logic [PIX_W-1:0] px, logic [PIX_W-1:0] py, logic typed,
                            logic signed [DIR_W-1:0] ex, logic signed [DIR_W-1:0] ey,
                            logic signed [DIR_W-1:0] ez);
    ray_t r;
    start <= 1'b1;
    pixel_x <= px;
    pixel_y <= py;
    do @(posedge clk); while (busy);
    r = trace_pixel(px, py);
    if (typed) begin
      r.dx = ex;
      r.dy = ey;
      r.dz = ez;
    end
    expected_rays.push_back(r);
    pixels_sent++;
    if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < idle_pct) @(posedge clk);
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    while (expected_rays.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic [CFG_W-1:0] rand_word();
    return {$urandom, $urandom};
  endfunction

  // check each ray against the oldest expectation
  always @(posedge clk) begin
    ray_t e;
    if (!rst && done) begin
      if (expected_rays.size() == 0) begin
        $display("%0t: unexpected ray dir=(%0d,%0d,%0d)", $time, dir_x, dir_y, dir_z);
        errors++;
      end else begin
        e = expected_rays.pop_front();
        rays_checked++;
        if (origin_x !== e.ox) begin
          $display("%0t: origin_x expected %0d got %0d", $time, e.ox, origin_x); errors++;
        end
        if (origin_y !== e.oy) begin
          $display("%0t: origin_y expected %0d got %0d", $time, e.oy, origin_y); errors++;
        end
        if (origin_z !== e.oz) begin
          $display("%0t: origin_z expected %0d got %0d", $time, e.oz, origin_z); errors++;
        end
        if (dir_x !== e.dx) begin
          $display("%0t: dir_x expected %0d got %0d", $time, e.dx, dir_x); errors++;
        end
        if (dir_y !== e.dy) begin
          $display("%0t: dir_y expected %0d got %0d", $time, e.dy, dir_y); errors++;
        end
        if (dir_z !== e.dz) begin
          $display("%0t: dir_z expected %0d got %0d", $time, e.dz, dir_z); errors++;
        end
      end
    end
  end

  // watchdog on cycles with no transaction
  always @(posedge clk) begin
    if (rst || (start && !busy) || done || cfg_we) begin
      stall_count <= 0;
    end else begin
      stall_count <= stall_count + 1;
      if (stall_count >= STALL_LIMIT) begin
        $display("primary_ray_generator_core test failed");
        $finish;
      end
    end
  end

  stim_row_t directed[] = '{
    '{ROW_PIX, REG_ORIGIN, '0, 16'd8, 16'd8, 1'b1, 16'sd0, 16'sd16384, 16'sd0},
    '{ROW_PIX, REG_ORIGIN, '0, 16'd0, 16'd0, 1'b0, 16'sd0, 16'sd0, 16'sd0},
    '{ROW_PIX, REG_ORIGIN, '0, 16'hFFFF, 16'hFFFF, 1'b0, 16'sd0, 16'sd0, 16'sd0},
    '{ROW_PIX, REG_ORIGIN, '0, 16'hFFFF, 16'd0, 1'b0, 16'sd0, 16'sd0, 16'sd0},
    '{ROW_PIX, REG_ORIGIN, '0, 16'd0, 16'hFFFF, 1'b0, 16'sd0, 16'sd0, 16'sd0},
    '{ROW_CFG, REG_WIDTH, 60'd0, 16'd0, 16'd0, 1'b0, 16'sd0, 16'sd0, 16'sd0},
    '{ROW_CFG, REG_HEIGHT, 60'd8191, 16'd0, 16'd0, 1'b0, 16'sd0, 16'sd0, 16'sd0},
    '{ROW_PIX, REG_ORIGIN, '0, 16'd8, 16'd32768, 1'b1, 16'sd0, 16'sd16384, 16'sd0},
    '{ROW_CFG, REG_SPARE_A, {CFG_W{1'b1}}, 16'd0, 16'd0, 1'b0, 16'sd0, 16'sd0, 16'sd0},
    '{ROW_CFG, REG_SPARE_B, {CFG_W{1'b1}}, 16'd0, 16'd0, 1'b0, 16'sd0, 16'sd0, 16'sd0},
    '{ROW_CFG, REG_ORIGIN, {CFG_W{1'b1}}, 16'd0, 16'd0, 1'b0, 16'sd0, 16'sd0, 16'sd0},
    '{ROW_CFG, REG_FORWARD, 60'd0, 16'd0, 16'd0, 1'b0, 16'sd0, 16'sd0, 16'sd0},
    '{ROW_PIX, REG_ORIGIN, '0, 16'd8, 16'd32768, 1'b1, 16'sd0, 16'sd0, 16'sd0},
    '{ROW_CFG, REG_HSTEP, 60'd0, 16'd0, 16'd0, 1'b0, 16'sd0, 16'sd0, 16'sd0},
    '{ROW_CFG, REG_VSTEP, 60'd0, 16'd0, 16'd0, 1'b0, 16'sd0, 16'sd0, 16'sd0},
    '{ROW_CFG, REG_FORWARD, 60'h20000, 16'd0, 16'd0, 1'b0, 16'sd0, 16'sd0, 16'sd0},
    '{ROW_PIX, REG_ORIGIN, '0, 16'd8, 16'd32768, 1'b1, -16'sd16384, 16'sd0, 16'sd0},
    '{ROW_CFG, REG_HSTEP, 60'h7FFFF_7FFFF_7FFFF, 16'd0, 16'd0, 1'b0, 16'sd0, 16'sd0, 16'sd0},
    '{ROW_CFG, REG_VSTEP, 60'h80000_80000_80000, 16'd0, 16'd0, 1'b0, 16'sd0, 16'sd0, 16'sd0},
    '{ROW_PIX, REG_ORIGIN, '0, 16'hFFFF, 16'd0, 1'b0, 16'sd0, 16'sd0, 16'sd0},
    '{ROW_PIX, REG_ORIGIN, '0, 16'd0, 16'hFFFF, 1'b0, 16'sd0, 16'sd0, 16'sd0},
    '{ROW_CFG, REG_WIDTH, 60'hFFFFFFFFFFFF000, 16'd0, 16'd0, 1'b0, 16'sd0, 16'sd0, 16'sd0},
    '{ROW_PIX, REG_ORIGIN, '0, 16'd32768, 16'd12345, 1'b0, 16'sd0, 16'sd0, 16'sd0}
  };

  initial begin
    int per_phase;
    int pick;
    cam_origin = ORIGIN_RST;
    cam_forward = FORWARD_RST;
    cam_hstep = HSTEP_RST;
    cam_vstep = VSTEP_RST;
    cam_width = 1;
    cam_height = 1;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed table
    foreach (directed[i]) begin
      if (directed[i].kind == ROW_CFG) begin
        drain();
        write_reg(directed[i].idx, directed[i].data);
      end else begin
        send_pixel(directed[i].px, directed[i].py, directed[i].typed,
                   directed[i].ex, directed[i].ey, directed[i].ez);
      end
    end

    // random phases, each with a fresh camera
    per_phase = RANDOM_ITEMS / PHASES;
    for (int ph = 0; ph < PHASES; ph++) begin
      drain();
      case (ph)
        0: idle_pct = 0;
        1: idle_pct = 75;
        2: idle_pct = 9;
        default: idle_pct = 30;
      endcase
      pick = $urandom_range(3);
      write_reg(REG_ORIGIN, rand_word());
      write_reg(REG_FORWARD, rand_word());
      write_reg(REG_HSTEP, (pick == 0) ? 60'h7FFFF_80000_7FFFF : rand_word());
      write_reg(REG_VSTEP, (pick == 0) ? 60'h80000_7FFFF_80000 : rand_word());
      write_reg(REG_WIDTH, (pick == 1) ? 60'd4096 : (pick == 2) ? 60'd1 : rand_word());
      write_reg(REG_HEIGHT, (pick == 1) ? 60'd1 : (pick == 2) ? 60'd4096 : rand_word());
      if ($urandom_range(1)) write_reg($urandom_range(1) ? REG_SPARE_A : REG_SPARE_B, rand_word());
      for (int n = 0; n < per_phase; n++) begin
        if ($urandom_range(3) == 0) begin
          send_pixel(16'(cam_width * 8 + $urandom_range(0, 64) - 32),
                     16'(cam_height * 8 + $urandom_range(0, 64) - 32), 1'b0, 0, 0, 0);
        end else begin
          send_pixel(16'($urandom), 16'($urandom), 1'b0, 0, 0, 0);
        end
      end
    end

    drain();
    $display("sent %0d pixels over %0d register writes, checked %0d rays", pixels_sent,
             cfg_writes, rays_checked);
    $display("covered reset camera, clamped resolutions, zero-length and saturated rays");
    if (errors == 0) begin
      $display("primary_ray_generator_core test passed");
    end else begin
      $display("primary_ray_generator_core test failed");
    end
    $finish;
  end

endmodule
`default_nettype wire

>>> files.f
sv/prg_pkg.sv
sv/prg_isqrt.sv
sv/prg_div.sv
sv/primary_ray_generator_core.sv
tb/sv/tb_primary_ray_generator_core.sv
